FILE: hdl/qln_pkg.sv
// Package for the quorum lock node: message codes, payload structs and sizes.
// No dependencies.
`timescale 1ns / 1ps
package qln_pkg;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int NODE_COUNT_DEF  = 32;
	localparam int KEY_W = 37;
	localparam logic [5:0] QUORUM_RESET = 6'd7;

	typedef enum logic [2:0] {
		OP_REQUEST    = 3'd0,
		OP_LOCKED     = 3'd1,
		OP_INQUIRE    = 3'd2,
		OP_RELEASE    = 3'd3,
		OP_RELINQUISH = 3'd4,
		OP_FAILED     = 3'd5,
		OP_START      = 3'd6,
		OP_NONE       = 3'd7
	} op_t;

	localparam logic [1:0] MSG_LOCKED     = 2'd0;
	localparam logic [1:0] MSG_FAILED     = 2'd1;
	localparam logic [1:0] MSG_INQUIRE    = 2'd2;
	localparam logic [1:0] MSG_RELINQUISH = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [4:0]  sender_node;
		logic [31:0] request_stamp;
	} in_word_t;

	typedef struct packed {
		logic        send_valid;
		logic [1:0]  send_type;
		logic [4:0]  send_dest;
		logic [5:0]  votes_held;
		logic        lock_acquired;
		logic        queue_overflow;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_OUT
	} state_t;
endpackage

FILE: hdl/qln_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module qln_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/quorum_lock_node_unit.sv
// Top level of the quorum lock node: voter and requester control around the wait-set RAM.
// Depends on qln_pkg and qln_ram.
`timescale 1ns / 1ps
// One node of quorum mutual exclusion. Each input word is one received message and yields
// exactly one output word. From a valid sender, request (while the lock is granted), release
// and relinquish sweep the wait-set RAM one slot a cycle through its single read port; their
// result is formed in a decide state after the sweep. Other messages retire in the scan state.
// One word is worked on at a time: the output register holds a result until taken, and the next
// word is accepted only in the idle cycle after it leaves, so a new word is never taken before
// the last result has gone.
// Wait-set slots carry valid bits in flip-flops, so no clearing pass follows reset.
module quorum_lock_node_unit
	import qln_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int NODE_COUNT  = NODE_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data,
	input  logic      cfg_we,
	input  logic [5:0] cfg_wdata
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;
	in_word_t req_q;
	logic [5:0] quorum_q, votes_q;
	logic failed_q, hvalid_q;
	logic [KEY_W-1:0] hkey_q;
	logic [QUEUE_DEPTH-1:0] wvalid_q;
	logic [CW-1:0] cnt_q;
	logic scan_s1;
	logic [AW-1:0] slot_s1;
	logic best_found_q, beaten_q, free_found_q;
	logic [AW-1:0] best_slot_q, free_slot_q;
	logic [KEY_W-1:0] best_key_q;
	out_word_t out_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [KEY_W-1:0] ram_wdata, ram_rdata;

	qln_ram #(.WIDTH(KEY_W), .DEPTH(QUEUE_DEPTH)) u_wait (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic [KEY_W-1:0] new_key;
	logic sender_ok, is_scan_op;
	assign new_key = {req_q.request_stamp, req_q.sender_node};
	assign sender_ok = {4'b0000, req_q.sender_node} < 9'(NODE_COUNT);
	assign is_scan_op = sender_ok && (req_q.op == OP_REQUEST || req_q.op == OP_RELEASE ||
		req_q.op == OP_RELINQUISH) && !(req_q.op == OP_REQUEST && !hvalid_q);
	assign ram_raddr = cnt_q[AW-1:0];
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   if (!is_scan_op || (!scan_s1 && cnt_q == CW'(QUEUE_DEPTH)))
				state_d = is_scan_op ? ST_DECIDE : ST_OUT;
			ST_DECIDE: state_d = ST_OUT;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// scan issue: one read per cycle, compare in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= 1'b0;
			if (state_q == ST_IDLE)
				cnt_q <= '0;
			else if (state_q == ST_SCAN && is_scan_op && cnt_q < CW'(QUEUE_DEPTH)) begin
				scan_s1 <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= ram_raddr;
		if (state_q == ST_IDLE && in_valid)
			req_q <= in_data;
		if (state_q == ST_IDLE) begin
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
			beaten_q <= hvalid_q && (hkey_q < {in_data.request_stamp, in_data.sender_node});
		end else if (scan_s1) begin
			if (wvalid_q[slot_s1]) begin
				if (ram_rdata < new_key)
					beaten_q <= 1'b1;
				if (!best_found_q || ram_rdata < best_key_q) begin
					best_found_q <= 1'b1;
					best_key_q <= ram_rdata;
					best_slot_q <= slot_s1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q <= slot_s1;
			end
		end
	end

	// decide and retire: state update, RAM write-back, result word
	out_word_t res;
	logic nhv, nfail, nwv_set, nwv_clr;
	logic [KEY_W-1:0] nhk;
	logic [5:0] nvotes;
	always_comb begin
		res = '0;
		nhv = hvalid_q;
		nhk = hkey_q;
		nvotes = votes_q;
		nfail = failed_q;
		ram_we = 1'b0;
		ram_waddr = free_slot_q;
		ram_wdata = new_key;
		nwv_set = 1'b0;
		nwv_clr = 1'b0;
		if (sender_ok) begin
			unique case (req_q.op)
				OP_REQUEST: begin
					res.send_valid = 1'b1;
					if (!hvalid_q) begin
						nhv = 1'b1;
						nhk = new_key;
						res.send_dest = req_q.sender_node;
					end else if (!free_found_q) begin
						res.queue_overflow = 1'b1;
						res.send_type = MSG_FAILED;
						res.send_dest = req_q.sender_node;
					end else begin
						ram_we = state_q == ST_DECIDE;
						nwv_set = 1'b1;
						res.send_type = beaten_q ? MSG_FAILED : MSG_INQUIRE;
						res.send_dest = beaten_q ? req_q.sender_node : hkey_q[4:0];
					end
				end
				OP_LOCKED: if (votes_q != 6'd63) nvotes = votes_q + 6'd1;
				OP_INQUIRE: if (failed_q) begin
					if (votes_q != 6'd0) nvotes = votes_q - 6'd1;
					res.send_valid = 1'b1;
					res.send_type = MSG_RELINQUISH;
					res.send_dest = req_q.sender_node;
				end
				OP_RELEASE, OP_RELINQUISH: begin
					if (req_q.op == OP_RELINQUISH && hvalid_q) begin
						res.send_valid = 1'b1;
						if (best_found_q && best_key_q < hkey_q) begin
							nhk = best_key_q;
							ram_we = state_q == ST_DECIDE;
							ram_waddr = best_slot_q;
							ram_wdata = hkey_q;
						end
						res.send_dest = nhk[4:0];
					end else if (best_found_q) begin
						nhv = 1'b1;
						nhk = best_key_q;
						nwv_clr = 1'b1;
						res.send_valid = 1'b1;
						res.send_dest = best_key_q[4:0];
					end else begin
						nhv = 1'b0;
						nhk = '0;
					end
				end
				OP_FAILED: nfail = 1'b1;
				OP_START:  nvotes = 6'd0;
				default: ;
			endcase
		end
		res.votes_held = nvotes;
		res.lock_acquired = nvotes >= quorum_q;
	end

	logic retire;
	assign retire = (state_q == ST_DECIDE) || (state_q == ST_SCAN && !is_scan_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quorum_q <= QUORUM_RESET;
			votes_q <= '0;
			failed_q <= 1'b0;
			hvalid_q <= 1'b0;
			hkey_q <= '0;
			wvalid_q <= '0;
		end else begin
			if (cfg_we)
				quorum_q <= cfg_wdata;
			if (retire) begin
				votes_q <= nvotes;
				failed_q <= nfail;
				hvalid_q <= nhv;
				hkey_q <= nhk;
				if (nwv_set) wvalid_q[free_slot_q] <= 1'b1;
				if (nwv_clr) wvalid_q[best_slot_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk)
		if (retire)
			out_q <= res;
endmodule
